[hw/rtl/mbd_pkg.sv]
package mbd_pkg;

	localparam int SIZE_W     = 13;
	localparam int ROW_W      = 12;
	localparam int MAX_HEIGHT = 4096;
	localparam int LANE_W     = 8;
	localparam int SUM_W      = 9;
	localparam int TOT_W      = 10;

	typedef enum logic [1:0] {
		FMT_A1R5G5B5 = 2'd0,
		FMT_A4R4G4B4 = 2'd1,
		FMT_R5G6B5   = 2'd2,
		FMT_ARGB8888 = 2'd3
	} fmt_t;

	typedef enum logic [1:0] {
		REG_PIXEL_FORMAT  = 2'd0,
		REG_SOURCE_WIDTH  = 2'd1,
		REG_SOURCE_HEIGHT = 2'd2
	} reg_idx_t;

	// Lane order is blue, green, red, alpha.
	typedef logic [3:0][LANE_W-1:0] lanes_t;
	typedef logic [3:0][SUM_W-1:0]  sums_t;
	typedef logic [3:0][TOT_W-1:0]  tots_t;

	function automatic lanes_t unpack_px(input fmt_t fmt, input logic [31:0] px);
		lanes_t l;
		l = '0;
		case (fmt)
			FMT_A1R5G5B5: begin
				l[0] = LANE_W'(px[4:0]);
				l[1] = LANE_W'(px[9:5]);
				l[2] = LANE_W'(px[14:10]);
				l[3] = LANE_W'(px[15]);
			end
			FMT_A4R4G4B4: begin
				l[0] = LANE_W'(px[3:0]);
				l[1] = LANE_W'(px[7:4]);
				l[2] = LANE_W'(px[11:8]);
				l[3] = LANE_W'(px[15:12]);
			end
			FMT_R5G6B5: begin
				l[0] = LANE_W'(px[4:0]);
				l[1] = LANE_W'(px[10:5]);
				l[2] = LANE_W'(px[15:11]);
			end
			default: begin
				l[0] = px[7:0];
				l[1] = px[15:8];
				l[2] = px[23:16];
				l[3] = px[31:24];
			end
		endcase
		return l;
	endfunction

	function automatic logic [31:0] pack_px(input fmt_t fmt, input tots_t tot);
		tots_t       avg;
		logic        a1;
		logic [31:0] px;
		for (int i = 0; i < 4; i++) begin
			avg[i] = (tot[i] + TOT_W'(2)) >> 2;
		end
		// Single-bit alpha goes by majority: at least two of the four set.
		a1 = (tot[3] >= TOT_W'(2));
		case (fmt)
			FMT_A1R5G5B5: px = {16'h0, a1, avg[2][4:0], avg[1][4:0], avg[0][4:0]};
			FMT_A4R4G4B4: px = {16'h0, avg[3][3:0], avg[2][3:0], avg[1][3:0], avg[0][3:0]};
			FMT_R5G6B5:   px = {16'h0, avg[2][4:0], avg[1][5:0], avg[0][4:0]};
			default:      px = {avg[3][7:0], avg[2][7:0], avg[1][7:0], avg[0][7:0]};
		endcase
		return px;
	endfunction

endpackage

[hw/rtl/mip_box_downsample_2x2_core.sv]
// A mip pixel passes stage 1, where the edge that accepts the bottom-right pixel of its
// quad pairs it and reads the line buffer, then the output register, which averages.
// Throughput: one source pixel per unstalled cycle, set by the single line buffer port pair.
// Reset clears position counters, the pending pixel and all pipeline valids; format resets
// to 8888, width to min(MAX_WIDTH, 4096), height to 4096. The line buffer is not cleared.
module mip_box_downsample_2x2_core #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [1:0]                cfg_index,
	input  logic [mbd_pkg::SIZE_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [31:0]               source_pixel,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [31:0]               mip_pixel,
	output logic                      frame_last
);
	import mbd_pkg::*;

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int XW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int YW         = ROW_W - 1;
	localparam int EW_RST     = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;

	fmt_t              fmt_q;
	logic [WW-1:0]     ew_q;
	logic [SIZE_W-1:0] eh_q;
	logic [31:0]       pend_q;
	logic [CW-1:0]     col_q;
	logic [ROW_W-1:0]  row_q;

	logic              valid_s1;
	sums_t             sums_s1;
	logic              dbl_s1;
	logic              last_s1;
	logic              out_valid_q;
	logic [31:0]       mip_q;
	logic              last_q;

	logic              in_acc;
	logic              cfg_hit;
	logic [WW-1:0]     ew_d;
	logic [SIZE_W-1:0] eh_d;
	logic              ew_one, eh_one;
	logic              pair_rdy, emit, rd_en, wr_en;
	logic [31:0]       partner;
	logic [XW-1:0]     x;
	logic [YW-1:0]     y, last_y;
	logic [WW-1:0]     last_x;
	logic              is_last;
	logic              col_wrap, row_wrap;
	sums_t             pair_sums;
	sums_t             line_rd;
	tots_t             tot;
	logic              out_free, s1_free;

	assign in_acc  = in_valid && !in_stall;
	assign cfg_hit = cfg_write && (cfg_index == REG_PIXEL_FORMAT
		|| cfg_index == REG_SOURCE_WIDTH || cfg_index == REG_SOURCE_HEIGHT);

	// Sizes are clamped once, at the register write.
	always_comb begin
		if (cfg_data == '0) begin
			ew_d = WW'(1);
		end else if (32'(cfg_data) > MAX_WIDTH) begin
			ew_d = WW'(MAX_WIDTH);
		end else begin
			ew_d = WW'(cfg_data);
		end
		if (cfg_data == '0) begin
			eh_d = SIZE_W'(1);
		end else if (cfg_data > SIZE_W'(MAX_HEIGHT)) begin
			eh_d = SIZE_W'(MAX_HEIGHT);
		end else begin
			eh_d = cfg_data;
		end
	end

	assign ew_one   = (ew_q == WW'(1));
	assign eh_one   = (eh_q == SIZE_W'(1));
	assign pair_rdy = ew_one || col_q[0];
	assign partner  = ew_one ? source_pixel : pend_q;
	assign x        = ew_one ? '0 : XW'(col_q >> 1);
	assign emit     = pair_rdy && (eh_one || row_q[0]);
	assign rd_en    = in_acc && pair_rdy && !eh_one && row_q[0];
	assign wr_en    = in_acc && pair_rdy && !eh_one && !row_q[0]
		&& ({1'b0, row_q} + SIZE_W'(1) < eh_q);

	assign y        = eh_one ? '0 : row_q[ROW_W-1:1];
	assign last_y   = eh_one ? '0 : YW'((eh_q >> 1) - SIZE_W'(1));
	assign last_x   = ew_one ? '0 : (ew_q >> 1) - WW'(1);
	assign is_last  = (WW'(x) == last_x) && (y == last_y);

	assign col_wrap = (WW'(col_q) + WW'(1) >= ew_q);
	assign row_wrap = ({1'b0, row_q} + SIZE_W'(1) >= eh_q);

	mbd_pair u_pair (
		.fmt   (fmt_q),
		.pix_a (partner),
		.pix_b (source_pixel),
		.sums  (pair_sums)
	);

	mbd_line_buf #(
		.DEPTH (LINE_DEPTH),
		.AW    (XW)
	) u_line_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (x),
		.wr_data (pair_sums),
		.rd_en   (rd_en),
		.rd_addr (x),
		.rd_data (line_rd)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign s1_free  = !valid_s1 || out_free;
	assign in_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= FMT_ARGB8888;
			ew_q   <= WW'(EW_RST);
			eh_q   <= SIZE_W'(MAX_HEIGHT);
			pend_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_PIXEL_FORMAT:  fmt_q <= fmt_t'(cfg_data[1:0]);
				REG_SOURCE_WIDTH:  ew_q  <= ew_d;
				REG_SOURCE_HEIGHT: eh_q  <= eh_d;
				default:           fmt_q <= fmt_q;
			endcase
			pend_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (in_acc) begin
			if (!pair_rdy) begin
				pend_q <= source_pixel;
			end
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_acc && emit;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			sums_s1 <= pair_sums;
			dbl_s1  <= eh_one;
			last_s1 <= is_last;
		end
	end

	// A single-row image doubles the pair sum instead of adding the row above.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tot[i] = dbl_s1 ? {sums_s1[i], 1'b0}
				: TOT_W'(sums_s1[i]) + TOT_W'(line_rd[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && out_free) begin
			mip_q  <= pack_px(fmt_q, tot);
			last_q <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign mip_pixel  = mip_q;
	assign frame_last = last_q;

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty first stage");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < ew_q)
		else $error("column counter beyond source width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row_q} < eh_q)
		else $error("row counter beyond source height");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && out_stall
		|=> valid_s1 && $stable(sums_s1) && $stable(line_rd))
		else $error("first stage changed while blocked");

endmodule

[hw/rtl/mbd_pair.sv]
module mbd_pair (
	input  mbd_pkg::fmt_t  fmt,
	input  logic [31:0]    pix_a,
	input  logic [31:0]    pix_b,
	output mbd_pkg::sums_t sums
);
	import mbd_pkg::*;

	lanes_t lanes_a;
	lanes_t lanes_b;

	assign lanes_a = unpack_px(fmt, pix_a);
	assign lanes_b = unpack_px(fmt, pix_b);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sums[i] = SUM_W'(lanes_a[i]) + SUM_W'(lanes_b[i]);
		end
	end

endmodule

[hw/rtl/mbd_line_buf.sv]
module mbd_line_buf #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  mbd_pkg::sums_t wr_data,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output mbd_pkg::sums_t rd_data
);
	import mbd_pkg::*;

	sums_t mem [DEPTH];
	sums_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data stays put unless a new read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
